FILE: rtl/core/button_chord_holdback_detector_macros.svh
// Assertion macros shared by the chord detector RTL
// Depends on nothing; included inside module bodies that assert
`ifndef BUTTON_CHORD_HOLDBACK_DETECTOR_MACROS_SVH
`define BUTTON_CHORD_HOLDBACK_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BCHD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bchd assertion failed");

// next-cycle implication, disabled during reset
`define BCHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bchd assertion failed");

`endif

FILE: rtl/core/bchd_pkg.sv
// Package for the button chord hold-back detector
// Holds field widths, button bit positions, register indexes and shared structs
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int BUTTON_W  = 16;
  localparam int TIME_BITS = 32;
  localparam int WINDOW_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int VIEW_BIT  = 5;
  localparam int MENU_BIT  = 4;
  localparam int GUIDE_BIT = 10;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd180;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHORD_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUIDE_OPENS   = 2'd1;

  typedef struct packed {
    logic [BUTTON_W-1:0]  button_word;
    logic                 pad_connected;
    logic                 menu_shown;
    logic [TIME_BITS-1:0] now_ms;
  } bchd_poll_t;

  typedef struct packed {
    logic hold_active;
    logic replay_view;
    logic replay_menu;
    logic open_guide;
  } bchd_result_t;

endpackage

FILE: rtl/core/bchd_core.sv
// Chord state and next-state logic for one poll per cycle while advance is high
// Depends on bchd_pkg and the assertion macro header
`timescale 1ns / 1ps

module bchd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  bchd_pkg::bchd_poll_t          poll,
  input  logic [bchd_pkg::WINDOW_W-1:0] chord_window_ms,
  input  logic                          guide_opens_menu,
  output bchd_pkg::bchd_result_t        result
);
  import bchd_pkg::*;
  `include "button_chord_holdback_detector_macros.svh"

  logic                 holding, holding_next;
  logic                 press_consumed, press_consumed_next;
  logic [1:0]           held_bits, held_bits_next;
  logic [TIME_BITS-1:0] hold_start_ms, hold_start_ms_next;
  logic                 guide_was_down, guide_was_down_next;

  // next state and result for the poll in the input register
  always_comb begin
    logic [BUTTON_W-1:0]  buttons;
    logic [1:0]           chord;
    logic [TIME_BITS-1:0] elapsed;
    logic                 guide_down;
    logic                 open;
    logic                 rep_view;
    logic                 rep_menu;
    buttons = poll.pad_connected ? poll.button_word : '0;
    chord = {buttons[MENU_BIT], buttons[VIEW_BIT]};
    guide_down = buttons[GUIDE_BIT];
    open = 1'b0;
    rep_view = 1'b0;
    rep_menu = 1'b0;
    holding_next = holding;
    press_consumed_next = press_consumed;
    held_bits_next = held_bits;
    hold_start_ms_next = hold_start_ms;
    elapsed = '0;

    if (poll.menu_shown) begin
      holding_next = 1'b0;
      press_consumed_next = 1'b0;
      held_bits_next = 2'b00;
    end else if (chord == 2'b00) begin
      // all released: replay whatever was held back
      if (holding && !press_consumed && (held_bits != 2'b00)) begin
        rep_view = held_bits[0];
        rep_menu = held_bits[1];
      end
      holding_next = 1'b0;
      press_consumed_next = 1'b0;
      held_bits_next = 2'b00;
    end else begin
      if (!holding && !press_consumed) begin
        holding_next = 1'b1;
        hold_start_ms_next = poll.now_ms;
      end
      held_bits_next = held_bits | chord;
      elapsed = poll.now_ms - hold_start_ms_next;
      if ((chord == 2'b11) && holding_next) begin
        // full chord: consume and open the guide
        holding_next = 1'b0;
        press_consumed_next = 1'b1;
        held_bits_next = 2'b00;
        open = 1'b1;
      end else if (holding_next &&
                   (elapsed > {{(TIME_BITS-WINDOW_W){1'b0}}, chord_window_ms})) begin
        // window ran out: lone press goes to the game
        holding_next = 1'b0;
        press_consumed_next = 1'b1;
        held_bits_next = 2'b00;
      end
    end

    // guide button rising edge
    guide_was_down_next = guide_down;
    if (guide_down && !guide_was_down && guide_opens_menu && !poll.menu_shown) begin
      open = 1'b1;
    end

    result.hold_active = holding_next;
    result.replay_view = rep_view;
    result.replay_menu = rep_menu;
    result.open_guide  = open;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
      press_consumed <= 1'b0;
      held_bits <= 2'b00;
      hold_start_ms <= '0;
      guide_was_down <= 1'b0;
    end else if (advance) begin
      holding <= holding_next;
      press_consumed <= press_consumed_next;
      held_bits <= held_bits_next;
      hold_start_ms <= hold_start_ms_next;
      guide_was_down <= guide_was_down_next;
    end
  end

  `BCHD_ASSERT_NOW(a_hold_has_bits, clk, rst, holding, held_bits != 2'b00)
  `BCHD_ASSERT_NOW(a_hold_not_consumed, clk, rst, holding, !press_consumed)
  `BCHD_ASSERT_NEXT(a_idle_keeps_hold, clk, rst, !advance, $stable(holding))

endmodule

FILE: rtl/core/button_chord_holdback_detector.sv
// Button chord hold-back detector: poll register, output register, config regs
// Depends on bchd_pkg, bchd_core and the assertion macro header
`timescale 1ns / 1ps

// Takes one gamepad poll per transfer and returns one result per poll, in order.
// A poll passes two registers: the poll register, where the chord state is
// updated, and the output register. Its result is offered from the output
// register once the poll has left the poll register, and is taken at a rising
// edge while out_stall is low. A poll can be accepted every cycle while in_stall
// is low; the state update loop adds no limit, and in_stall rises only when both
// registers are full and the output side stalls. Configuration writes take
// effect at once and are expected only while no poll is in flight.
module button_chord_holdback_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bchd_pkg::BUTTON_W-1:0]   button_word,
  input  logic                            pad_connected,
  input  logic                            menu_shown,
  input  logic [bchd_pkg::TIME_BITS-1:0]  now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hold_active,
  output logic                            replay_view,
  output logic                            replay_menu,
  output logic                            open_guide,
  input  logic                            cfg_we,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bchd_pkg::*;
  `include "button_chord_holdback_detector_macros.svh"

  logic [WINDOW_W-1:0] chord_window_ms;
  logic                guide_opens_menu;
  logic                s1_valid;
  bchd_poll_t          s1_poll;
  bchd_result_t        s1_result;
  bchd_result_t        out_result;
  logic                out_free;
  logic                s1_move;
  logic                in_take;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_window_ms <= WINDOW_RESET;
      guide_opens_menu <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHORD_WINDOW: chord_window_ms <= cfg_data[WINDOW_W-1:0];
        REG_GUIDE_OPENS:  guide_opens_menu <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_poll.button_word <= button_word;
      s1_poll.pad_connected <= pad_connected;
      s1_poll.menu_shown <= menu_shown;
      s1_poll.now_ms <= now_ms;
    end
  end

  bchd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .advance          (s1_move),
    .poll             (s1_poll),
    .chord_window_ms  (chord_window_ms),
    .guide_opens_menu (guide_opens_menu),
    .result           (s1_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_result <= s1_result;
    end
  end

  assign hold_active = out_result.hold_active;
  assign replay_view = out_result.replay_view;
  assign replay_menu = out_result.replay_menu;
  assign open_guide  = out_result.open_guide;

  `BCHD_ASSERT_NOW(a_stall_only_full, clk, rst, in_stall, s1_valid)
  `BCHD_ASSERT_NOW(a_no_overwrite, clk, rst, s1_move, !(out_valid && out_stall))
  `BCHD_ASSERT_NOW(a_replay_ends_hold, clk, rst,
                   out_valid && (replay_view || replay_menu), !hold_active)
  `BCHD_ASSERT_NEXT(a_move_fills_out, clk, rst, s1_move, out_valid)

endmodule

FILE: dv/button_chord_holdback_detector_test.sv
// Self-checking testbench for the button chord hold-back detector
// Depends on bchd_pkg and the button_chord_holdback_detector RTL
`timescale 1ns / 1ps

module button_chord_holdback_detector_test;
  import bchd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 5;
  localparam int POLLS_PER_PHASE = 220;

  localparam logic [BUTTON_W-1:0] VIEW_BTN   = BUTTON_W'(1) << VIEW_BIT;
  localparam logic [BUTTON_W-1:0] MENU_BTN   = BUTTON_W'(1) << MENU_BIT;
  localparam logic [BUTTON_W-1:0] GUIDE_BTN  = BUTTON_W'(1) << GUIDE_BIT;
  localparam logic [BUTTON_W-1:0] OTHER_BTNS = ~(VIEW_BTN | MENU_BTN | GUIDE_BTN);

  // chord codes: bit 0 view, bit 1 menu
  localparam logic [1:0] CHORD_NONE = 2'b00;
  localparam logic [1:0] CHORD_BOTH = 2'b11;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {
    G_TAP_VIEW, G_TAP_MENU, G_CHORD, G_STAGGER, G_LONG_HOLD,
    G_GUIDE, G_MENU_SHOWN, G_UNPLUG, G_NOISE
  } gesture_e;

  typedef enum int {RX_READY, RX_RANDOM, RX_BLOCKED} rx_pattern_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BUTTON_W-1:0]   button_word = '0;
  logic                  pad_connected = 1'b0;
  logic                  menu_shown = 1'b0;
  logic [TIME_BITS-1:0]  now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hold_active;
  logic                  replay_view;
  logic                  replay_menu;
  logic                  open_guide;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of block state and registers
  logic                 hold_q;
  logic                 consumed_q;
  logic [1:0]           held_q;
  logic [TIME_BITS-1:0] hold_start_q;
  logic                 guide_prev_q;
  logic [WINDOW_W-1:0]  window_q;
  logic                 guide_en_q;

  bchd_result_t chord_results_due[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit sender_idle = 1'b1;
  rx_pattern_e rx_mode = RX_READY;
  int rx_mode_left = 0;

  button_chord_holdback_detector u_dut (.*);

  always #5 clk = ~clk;

  // expected result of one poll; advances the predictor state
  function automatic bchd_result_t predict_chord_result(bchd_poll_t poll);
    logic [BUTTON_W-1:0]  pressed;
    logic [1:0]           chord;
    logic [TIME_BITS-1:0] elapsed;
    logic                 guide_now;
    bchd_result_t         res;
    res = '0;
    pressed = poll.pad_connected ? poll.button_word : '0;
    chord = {pressed[MENU_BIT], pressed[VIEW_BIT]};
    if (poll.menu_shown) begin
      hold_q = 1'b0;
      consumed_q = 1'b0;
      held_q = 2'b00;
    end else if (chord == CHORD_NONE) begin
      // release: replay what was held unless the press was consumed
      if (hold_q) begin
        hold_q = 1'b0;
        if (!consumed_q) begin
          res.replay_view = held_q[0];
          res.replay_menu = held_q[1];
        end
      end
      consumed_q = 1'b0;
      held_q = 2'b00;
    end else begin
      if (!hold_q && !consumed_q) begin
        hold_q = 1'b1;
        hold_start_q = poll.now_ms;
      end
      held_q = held_q | chord;
      elapsed = poll.now_ms - hold_start_q;
      if (chord == CHORD_BOTH && hold_q) begin
        hold_q = 1'b0;
        consumed_q = 1'b1;
        held_q = 2'b00;
        res.open_guide = 1'b1;
      end else if (hold_q && elapsed > window_q) begin
        hold_q = 1'b0;
        consumed_q = 1'b1;
        held_q = 2'b00;
      end
    end
    // guide rising edge
    guide_now = pressed[GUIDE_BIT];
    if (guide_now && !guide_prev_q && guide_en_q && !poll.menu_shown) begin
      res.open_guide = 1'b1;
    end
    guide_prev_q = guide_now;
    res.hold_active = hold_q;
    return res;
  endfunction

  // receiver stall pattern, switching between modes
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_pattern_e'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(16, 96);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_READY: out_stall <= 1'b0;
      RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  // result check, poll prediction, register tracking and watchdog
  always @(posedge clk) begin : monitor
    bchd_result_t got;
    bchd_result_t want;
    bchd_poll_t   poll;
    if (rst) begin
      hold_q = 1'b0;
      consumed_q = 1'b0;
      held_q = 2'b00;
      hold_start_q = '0;
      guide_prev_q = 1'b0;
      window_q = WINDOW_RESET;
      guide_en_q = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {hold_active, replay_view, replay_menu, open_guide};
        if (chord_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result at %0t: hold=%b view=%b menu=%b guide=%b",
                     $realtime, got.hold_active, got.replay_view, got.replay_menu,
                     got.open_guide);
          end
        end else begin
          want = chord_results_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch at %0t: hold/view/menu/guide expected %b%b%b%b got %b%b%b%b",
                       $realtime, want.hold_active, want.replay_view, want.replay_menu,
                       want.open_guide, got.hold_active, got.replay_view, got.replay_menu,
                       got.open_guide);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        poll = {button_word, pad_connected, menu_shown, now_ms};
        chord_results_due.push_back(predict_chord_result(poll));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CHORD_WINDOW: window_q = cfg_data[WINDOW_W-1:0];
          REG_GUIDE_OPENS: guide_en_q = cfg_data[0];
          default: ;
        endcase
      end
      // watchdog on cycles without any transfer
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one poll transfer, with bursts and, while sender_idle is set, random gaps in front
  task automatic send_poll(input logic [BUTTON_W-1:0] word, input logic conn,
                           input logic shown, input logic [TIME_BITS-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (sender_idle && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    button_word <= word;
    pad_connected <= conn;
    menu_shown <= shown;
    now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (chord_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write spare indexes, then the window and guide enable
  task automatic program_registers(input logic [WINDOW_W-1:0] window, input logic guide_en);
    cfg_we <= 1'b1;
    cfg_index <= REG_SPARE_A;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_CHORD_WINDOW;
    cfg_data <= window;
    @(posedge clk);
    cfg_index <= REG_GUIDE_OPENS;
    cfg_data <= (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(guide_en);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // taps, chord, window edge, disconnect, menu and timestamp wrap at reset values
  task automatic test_reset_defaults();
    send_poll(VIEW_BTN, 1'b1, 1'b0, 32'd1000);
    send_poll('0, 1'b1, 1'b0, 32'd1050);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'd1100);
    send_poll('1, 1'b0, 1'b0, 32'd1120);
    send_poll('1, 1'b1, 1'b0, 32'd1200);
    send_poll('0, 1'b1, 1'b0, 32'd1210);
    send_poll(VIEW_BTN, 1'b1, 1'b0, 32'd1300);
    send_poll(VIEW_BTN, 1'b1, 1'b0, 32'd1480);
    send_poll(VIEW_BTN, 1'b1, 1'b0, 32'd1481);
    send_poll('0, 1'b1, 1'b0, 32'd1490);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'hFFFF_FF80);
    send_poll(MENU_BTN | GUIDE_BTN, 1'b1, 1'b0, 32'h0000_0034);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'h0000_0035);
    send_poll('0, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'd0);
    send_poll(MENU_BTN, 1'b1, 1'b1, 32'd5);
  endtask

  // zero and full window, guide edge enabled and blocked by a menu
  task automatic test_register_extremes();
    wait_results_drained();
    program_registers('0, 1'b1);
    send_poll(GUIDE_BTN, 1'b1, 1'b0, 32'd20);
    send_poll(GUIDE_BTN, 1'b1, 1'b0, 32'd21);
    send_poll('0, 1'b1, 1'b0, 32'd22);
    send_poll(GUIDE_BTN, 1'b1, 1'b1, 32'd23);
    send_poll(VIEW_BTN, 1'b1, 1'b0, 32'd30);
    send_poll(VIEW_BTN, 1'b1, 1'b0, 32'd31);
    send_poll('0, 1'b1, 1'b0, 32'd32);
    wait_results_drained();
    program_registers('1, 1'b0);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'd100);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'd100 + 32'd65535);
    send_poll(MENU_BTN, 1'b1, 1'b0, 32'd100 + 32'd65536);
    send_poll('0, 1'b1, 1'b0, 32'd100 + 32'd65540);
  endtask

  // one press-and-release sequence with random content
  task automatic play_gesture(inout logic [TIME_BITS-1:0] clock_ms, inout int sent);
    gesture_e            kind;
    int unsigned         r;
    int unsigned         n;
    int unsigned         rel;
    int unsigned         win;
    int unsigned         dt;
    logic [BUTTON_W-1:0] lone;
    logic [BUTTON_W-1:0] word;
    logic                conn;
    logic                shown;
    logic                guide_blocked;
    r = $urandom_range(0, 9);
    kind = (r >= G_NOISE) ? G_NOISE : gesture_e'(r);
    n = $urandom_range(2, 8);
    rel = $urandom_range(1, 3);
    win = window_q;
    lone = $urandom_range(0, 1) ? MENU_BTN : VIEW_BTN;
    guide_blocked = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n + rel; i++) begin
      word = ($urandom_range(0, 2) == 0) ? (BUTTON_W'($urandom) & OTHER_BTNS) : '0;
      conn = 1'b1;
      shown = 1'b0;
      if (kind != G_GUIDE && $urandom_range(0, 15) == 0) begin
        word = word | GUIDE_BTN;
      end
      if (i < n) begin
        case (kind)
          G_TAP_VIEW: word = word | VIEW_BTN;
          G_TAP_MENU: word = word | MENU_BTN;
          G_CHORD: word = word | VIEW_BTN | MENU_BTN;
          G_STAGGER: word = word | ((i < n / 2) ? lone : (VIEW_BTN | MENU_BTN));
          G_LONG_HOLD: word = word | lone;
          G_GUIDE: begin
            word = word | GUIDE_BTN;
            shown = guide_blocked;
          end
          G_MENU_SHOWN: begin
            word = word | lone;
            shown = (i == n - 1);
          end
          G_UNPLUG: begin
            word = word | lone;
            if (i == n - 1) begin
              word = BUTTON_W'($urandom);
              conn = 1'b0;
            end
          end
          default: begin
            word = BUTTON_W'($urandom);
            conn = ($urandom_range(0, 3) != 0);
            shown = ($urandom_range(0, 3) == 0);
          end
        endcase
      end
      // time step scaled to the window; rare large jumps wrap the clock
      if (kind == G_LONG_HOLD) begin
        dt = $urandom_range(win / 2, win + win / 2 + 2);
      end else begin
        dt = $urandom_range(0, win / 4 + 2);
      end
      if ($urandom_range(0, 63) == 0) begin
        dt = $urandom;
      end
      clock_ms = clock_ms + dt;
      send_poll(word, conn, shown, clock_ms);
      sent++;
    end
  endtask

  // random gestures over several register settings
  task automatic test_random_gestures();
    logic [TIME_BITS-1:0] clock_ms;
    int                   sent;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_results_drained();
      case (p)
        0: program_registers(16'd1, 1'b1);
        1: program_registers(WINDOW_W'($urandom_range(2, 400)), 1'b0);
        2: program_registers('0, 1'b1);
        3: program_registers('1, 1'($urandom_range(0, 1)));
        default: program_registers(WINDOW_W'($urandom), 1'b1);
      endcase
      sender_idle = (p != 2);
      clock_ms = (p == 3) ? (32'hFFFF_0000 + $urandom_range(0, 16'hFFFF)) : $urandom;
      sent = 0;
      while (sent < POLLS_PER_PHASE) play_gesture(clock_ms, sent);
    end
    sender_idle = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_gestures();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bchd_pkg.sv
rtl/core/bchd_core.sv
rtl/core/button_chord_holdback_detector.sv
dv/button_chord_holdback_detector_test.sv
